@@ design/xsf_pkg.sv @@
// Package for the XOR sprite frame buffer: screen geometry, command codes,
// beat structs and the small modular-reduction helper. Depends on nothing.
package xsf_pkg;

	localparam int DISPLAY_WIDTH  = 64;
	localparam int DISPLAY_HEIGHT = 32;

	localparam int ROW_AW     = $clog2(DISPLAY_HEIGHT);
	localparam int COL_AW     = $clog2(DISPLAY_WIDTH);
	localparam int SPRITE_W   = 8;
	localparam int DATA_W     = 64;
	localparam int MOD_STEPS  = 6;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [3:0] row_offset;
		logic [7:0] sprite_byte;
	} cmd_t;

	typedef struct packed {
		logic              collision;
		logic [DATA_W-1:0] row_data;
	} rsp_t;

	typedef struct packed {
		logic                     wr_en;
		logic [ROW_AW-1:0]        wr_row;
		logic [DISPLAY_WIDTH-1:0] wr_data;
		logic                     clr_all;
	} store_req_t;

	// Reduces a value below 512 modulo a constant of at least 8 by
	// conditional subtraction of shifted copies of the modulus.
	function automatic logic [15:0] reduce_mod(input logic [15:0] value,
			input logic [15:0] modulus);
		logic [15:0] rem;
		rem = value;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (rem >= (modulus << k)) begin
				rem = rem - (modulus << k);
			end
		end
		return rem;
	endfunction

endpackage

@@ design/xor_sprite_framebuffer.sv @@
// Top level of the XOR sprite frame buffer: command register, result register
// and collision flag. Depends on xsf_pkg, xsf_exec and xsf_row_store.
//
// A command is taken on every clock edge with start high; busy stays low, so
// one command per cycle is sustained. The accepting edge loads the command
// register and the next edge loads the result register and done through the
// row logic, so the result is on result with done high and is captured at
// the edge that follows.
// The receiver cannot stall, so every result must be captured when done is
// high. A screen clear completes like any other command, since the rows
// are held in flip-flops with a per-row valid bit cleared by reset or clear.
module xor_sprite_framebuffer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  xsf_pkg::cmd_t  cmd,
	output logic           done,
	output xsf_pkg::rsp_t  result
);
	import xsf_pkg::*;

	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic                     acc_q;
	logic                     done_q;
	rsp_t                     result_q;
	logic [ROW_AW-1:0]        rd_row;
	logic [DISPLAY_WIDTH-1:0] cur_row;
	store_req_t               req;
	store_req_t               req_gated;
	logic                     acc_next;
	rsp_t                     rsp;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			acc_q    <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
			if (valid_s1) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			result_q <= rsp;
		end
	end

	always_comb begin
		req_gated         = req;
		req_gated.wr_en   = req.wr_en && valid_s1;
		req_gated.clr_all = req.clr_all && valid_s1;
	end

	xsf_exec u_exec (
		.cmd      (cmd_s1),
		.acc      (acc_q),
		.rd_row   (rd_row),
		.cur_row  (cur_row),
		.req      (req),
		.acc_next (acc_next),
		.rsp      (rsp)
	);

	xsf_row_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_row  (rd_row),
		.rd_data (cur_row),
		.req     (req_gated)
	);

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/xsf_row_store.sv @@
// Frame store of DISPLAY_HEIGHT rows held in flip-flops, with one valid bit
// per row so a clear resets only the valid bits. Depends on xsf_pkg.
module xsf_row_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [xsf_pkg::ROW_AW-1:0]       rd_row,
	output logic [xsf_pkg::DISPLAY_WIDTH-1:0] rd_data,
	input  xsf_pkg::store_req_t              req
);
	import xsf_pkg::*;

	logic [DISPLAY_WIDTH-1:0]  rows_q [DISPLAY_HEIGHT];
	logic [DISPLAY_HEIGHT-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr_all) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_row] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			rows_q[req.wr_row] <= req.wr_data;
		end
	end

	assign rd_data = valid_q[rd_row] ? rows_q[rd_row] : '0;

endmodule

@@ design/xsf_exec.sv @@
// Combinational command logic: row address wrap, sprite placement with column
// wrap, XOR, collision update and result formation. Depends on xsf_pkg.
module xsf_exec (
	input  xsf_pkg::cmd_t                     cmd,
	input  logic                              acc,
	output logic [xsf_pkg::ROW_AW-1:0]        rd_row,
	input  logic [xsf_pkg::DISPLAY_WIDTH-1:0] cur_row,
	output xsf_pkg::store_req_t               req,
	output logic                              acc_next,
	output xsf_pkg::rsp_t                     rsp
);
	import xsf_pkg::*;

	logic [15:0]              row_sum;
	logic [15:0]              row_mod;
	logic [15:0]              x_mod;
	logic [COL_AW:0]          col;
	logic [DISPLAY_WIDTH-1:0] spr;
	logic [DISPLAY_WIDTH-1:0] new_row;
	logic                     hit;

	always_comb begin
		if (cmd.op == OP_DRAW) begin
			row_sum = 16'(cmd.y_pos) + 16'(cmd.row_offset);
		end else begin
			row_sum = 16'(cmd.y_pos);
		end
		row_mod = reduce_mod(row_sum, 16'(DISPLAY_HEIGHT));
	end

	assign rd_row = row_mod[ROW_AW-1:0];

	always_comb begin
		x_mod = reduce_mod(16'(cmd.x_pos), 16'(DISPLAY_WIDTH));
		spr   = '0;
		col   = '0;
		for (int b = 0; b < SPRITE_W; b++) begin
			col = (COL_AW + 1)'(x_mod) + (COL_AW + 1)'(b);
			if (col >= (COL_AW + 1)'(DISPLAY_WIDTH)) begin
				col = col - (COL_AW + 1)'(DISPLAY_WIDTH);
			end
			if (cmd.sprite_byte[SPRITE_W - 1 - b]) begin
				spr[col[COL_AW-1:0]] = 1'b1;
			end
		end
	end

	assign hit     = |(cur_row & spr);
	assign new_row = cur_row ^ spr;

	always_comb begin
		req.wr_en   = 1'b0;
		req.wr_row  = rd_row;
		req.wr_data = new_row;
		req.clr_all = 1'b0;
		acc_next    = acc;
		rsp.row_data = '0;
		unique case (cmd.op)
			OP_CLEAR: begin
				req.clr_all = 1'b1;
				acc_next    = 1'b0;
			end
			OP_DRAW: begin
				req.wr_en    = 1'b1;
				acc_next     = ((cmd.row_offset == 4'd0) ? 1'b0 : acc) | hit;
				rsp.row_data = DATA_W'(new_row);
			end
			OP_READ: begin
				rsp.row_data = DATA_W'(cur_row);
			end
			default: begin
				acc_next = acc;
			end
		endcase
		rsp.collision = acc_next;
	end

endmodule

@@ design/xsf_checker.sv @@
// Port-level checker for the XOR sprite frame buffer and its bind statement.
// Depends on xsf_pkg and the top level xor_sprite_framebuffer.
module xsf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input xsf_pkg::cmd_t cmd,
	input logic          done,
	input xsf_pkg::rsp_t result
);
	import xsf_pkg::*;

	// Every accepted beat is followed by a result with done high.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted beat produced no result");

	// No result without an earlier accepted beat.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, 2))
		else $error("result without an accepted beat");

	// A clear returns an empty row and a cleared collision flag.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && arst_n && cmd.op == OP_CLEAR, 2)
		|-> (result.row_data == '0) && !result.collision)
		else $error("clear result not zero");

	// A read right after a clear sees an empty row.
	a_read_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && arst_n && cmd.op == OP_CLEAR, 3)
		&& $past(start && !busy && arst_n && cmd.op == OP_READ, 2)
		|-> result.row_data == '0)
		else $error("read after clear returned lit pixels");

endmodule

bind xor_sprite_framebuffer xsf_checker u_xsf_checker (.*);

@@ sim/tb_xor_sprite_framebuffer.sv @@
// Self-checking testbench for xor_sprite_framebuffer: directed and random command beats
// are checked against an in-bench model of the frame store and the collision flag.
// Depends on xsf_pkg and the xor_sprite_framebuffer RTL.
module tb_xor_sprite_framebuffer;
	timeunit 1ns;
	timeprecision 1ps;

	import xsf_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         MAX_REPORTS = 10;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	cmd_t  cmd;
	logic  done;
	rsp_t  result;

	logic [DISPLAY_WIDTH-1:0] model_rows [DISPLAY_HEIGHT];
	logic                     model_collision;
	rsp_t                     pending_rsp [$];
	int                       mismatches;
	int                       cycle_count;
	bit                       idle_off;

	xor_sprite_framebuffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[xor_sprite_framebuffer] ERROR");
			$finish;
		end
	end

	function automatic rsp_t apply_cmd(input cmd_t c);
		rsp_t                     r;
		logic [DISPLAY_WIDTH-1:0] sprite_bits;
		int                       row;
		r = '0;
		sprite_bits = '0;
		if (c.op == OP_CLEAR) begin
			for (int i = 0; i < DISPLAY_HEIGHT; i++) begin
				model_rows[i] = '0;
			end
			model_collision = 1'b0;
		end else if (c.op == OP_DRAW) begin
			row = (int'(c.y_pos) + int'(c.row_offset)) % DISPLAY_HEIGHT;
			for (int b = 0; b < 8; b++) begin
				if (c.sprite_byte[7 - b]) begin
					sprite_bits[(int'(c.x_pos) + b) % DISPLAY_WIDTH] = 1'b1;
				end
			end
			if (c.row_offset == 4'd0) begin
				model_collision = 1'b0;
			end
			if ((model_rows[row] & sprite_bits) != '0) begin
				model_collision = 1'b1;
			end
			model_rows[row] = model_rows[row] ^ sprite_bits;
			r.row_data = DATA_W'(model_rows[row]);
		end else if (c.op == OP_READ) begin
			r.row_data = DATA_W'(model_rows[int'(c.y_pos) % DISPLAY_HEIGHT]);
		end
		r.collision = model_collision;
		return r;
	endfunction

	// Results are checked before the beat taken at the same edge is queued.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected result: collision %0b row_data %h",
							result.collision, result.row_data);
					end
				end else begin
					exp_rsp = pending_rsp.pop_front();
					if (result.collision !== exp_rsp.collision) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("collision mismatch: expected %0b actual %0b",
								exp_rsp.collision, result.collision);
						end
					end
					if (result.row_data !== exp_rsp.row_data) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("row_data mismatch: expected %h actual %h",
								exp_rsp.row_data, result.row_data);
						end
					end
				end
			end
			if (start && !busy) begin
				pending_rsp.push_back(apply_cmd(cmd));
			end
		end
	end

	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = 0;
		while (!idle_off && $urandom_range(99) < 34) begin
			gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task automatic send_fields(input logic [1:0] op, input logic [7:0] x,
			input logic [7:0] y, input logic [3:0] off, input logic [7:0] spr);
		cmd_t c;
		c.op          = op;
		c.x_pos       = x;
		c.y_pos       = y;
		c.row_offset  = off;
		c.sprite_byte = spr;
		send_cmd(c);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_fields(OP_READ, 8'd0, 8'd0, 4'd0, 8'd0);
		send_fields(OP_READ, 8'hFF, 8'd31, 4'hF, 8'hFF);
		send_fields(OP_READ, 8'd0, 8'd255, 4'd0, 8'd0);
		send_fields(OP_READ, 8'd0, 8'd32, 4'd0, 8'd0);
	endtask

	task automatic test_draw_wrap();
		send_fields(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF);
		send_fields(OP_DRAW, 8'd60, 8'd31, 4'd0, 8'hA5);
		send_fields(OP_DRAW, 8'd255, 8'd255, 4'hF, 8'h81);
		send_fields(OP_DRAW, 8'd0, 8'd0, 4'd1, 8'h00);
		send_fields(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF);
		send_fields(OP_DRAW, 8'd64, 8'd31, 4'd1, 8'h01);
		send_fields(OP_DRAW, 8'd63, 8'd14, 4'd0, 8'h80);
		send_fields(OP_READ, 8'd0, 8'd14, 4'd0, 8'd0);
		send_fields(OP_READ, 8'd0, 8'd63, 4'd0, 8'd0);
	endtask

	task automatic test_unused_op();
		send_fields(OP_DRAW, 8'd3, 8'd5, 4'd0, 8'hF0);
		send_fields(OP_DRAW, 8'd3, 8'd4, 4'd1, 8'h10);
		send_fields(OP_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF);
		send_fields(OP_UNUSED, 8'h00, 8'h00, 4'h0, 8'h00);
		send_fields(OP_READ, 8'd0, 8'd5, 4'd0, 8'd0);
	endtask

	task automatic test_clear();
		send_fields(OP_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF);
		send_fields(OP_READ, 8'd0, 8'd5, 4'd0, 8'd0);
		send_fields(OP_READ, 8'd0, 8'd0, 4'd0, 8'd0);
		send_fields(OP_DRAW, 8'd62, 8'd0, 4'd0, 8'hFF);
		send_fields(OP_CLEAR, 8'd0, 8'd0, 4'd0, 8'd0);
		send_fields(OP_READ, 8'd0, 8'd0, 4'd0, 8'd0);
	endtask

	task automatic test_random_sprites(input int n_items);
		cmd_t       c;
		int         sent;
		int         sel;
		int         n_rows;
		logic [7:0] sx;
		logic [7:0] sy;
		sent = 0;
		while (sent < n_items) begin
			idle_off = (sent >= n_items / 3) && (sent < n_items / 2);
			sel = $urandom_range(99);
			if (sel < 65) begin
				if ($urandom_range(1) == 0) begin
					sx = 8'($urandom_range(2) * 4);
					sy = 8'($urandom_range(3));
				end else begin
					sx = 8'($urandom);
					sy = 8'($urandom);
				end
				n_rows = $urandom_range(1, 15);
				for (int r = 0; r < n_rows; r++) begin
					c.op          = OP_DRAW;
					c.x_pos       = sx;
					c.y_pos       = sy;
					c.row_offset  = ($urandom_range(7) == 0) ? 4'($urandom) : 4'(r);
					c.sprite_byte = 8'($urandom);
					send_cmd(c);
					sent++;
				end
			end else if (sel < 85) begin
				send_fields(OP_READ, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
				sent++;
			end else if (sel < 88) begin
				send_fields(OP_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
					8'($urandom));
				sent++;
			end else begin
				c = cmd_t'($bits(cmd_t)'($urandom));
				send_cmd(c);
				sent++;
			end
		end
		idle_off = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		mismatches      = 0;
		cycle_count     = 0;
		idle_off        = 1'b0;
		model_collision = 1'b0;
		for (int i = 0; i < DISPLAY_HEIGHT; i++) begin
			model_rows[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_draw_wrap();
		test_unused_op();
		test_clear();
		test_random_sprites(700);
		drain_results();
		test_random_sprites(800);
		drain_results();
		repeat (4) @(posedge clk);

		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("[xor_sprite_framebuffer] OK");
		end else begin
			$display("[xor_sprite_framebuffer] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/xsf_pkg.sv
design/xsf_row_store.sv
design/xsf_exec.sv
design/xor_sprite_framebuffer.sv
design/xsf_checker.sv
sim/tb_xor_sprite_framebuffer.sv
